// ===== rtl/lbc_pkg.sv =====
// Package for the LRU block buffer cache: sizes, command and status codes,
// state machine type and the front-to-back item struct. No dependencies.
package lbc_pkg;
    localparam int SLOTS      = 32;
    localparam int COUNT_BITS = 8;
    localparam int SLOT_BITS  = $clog2(SLOTS);
    localparam int DEV_BITS   = 8;
    localparam int BLK_BITS   = 32;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [1:0] CMD_GET     = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_MARK    = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOBUF = 2'd1;
    localparam logic [1:0] ST_UNREF = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE, S_HSCAN, S_FSCAN, S_AGE, S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [DEV_BITS-1:0] device;
        logic [BLK_BITS-1:0] block_number;
        logic [4:0]          slot;
    } t_item;
endpackage

// ===== rtl/lbc_front.sv =====
// Front part: accepts commands and queues them (two-entry queue).
// Depends on lbc_pkg.
module lbc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  lbc_pkg::t_item i_item,
    output logic           o_avail,
    output lbc_pkg::t_item o_item,
    input  logic           i_take
);
    lbc_pkg::t_item r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd, r_wr;
    logic       w_push;

    assign o_full  = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rd];
    assign w_push  = i_push && !o_full;

    // queue pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (w_push) r_wr <= !r_wr;
            if (i_take && o_avail) r_rd <= !r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_take && o_avail};
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wr] <= i_item;
    end
endmodule

// ===== rtl/lbc_back.sv =====
// Back part: slot table and sequencer that scans slots one per cycle.
// Depends on lbc_pkg.
module lbc_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_avail,
    input  lbc_pkg::t_item                 i_item,
    output logic                           o_take,
    output logic                           o_empty,
    input  logic                           i_pop,
    output logic [4:0]                     o_slot_index,
    output logic                           o_hit,
    output logic                           o_data_valid,
    output logic [1:0]                     o_status
);
    localparam int SB = lbc_pkg::SLOT_BITS;

    logic [lbc_pkg::DEV_BITS-1:0]   r_tdev [lbc_pkg::SLOTS];
    logic [lbc_pkg::BLK_BITS-1:0]   r_tblk [lbc_pkg::SLOTS];
    logic [lbc_pkg::SLOTS-1:0]      r_vld;
    logic [lbc_pkg::COUNT_BITS-1:0] r_cnt  [lbc_pkg::SLOTS];
    logic [SB-1:0]                  r_rank [lbc_pkg::SLOTS];

    lbc_pkg::t_state r_state, n_state;
    lbc_pkg::t_item  r_it;
    logic [SB-1:0]   r_i;
    logic            r_found;
    logic [SB-1:0]   r_best, r_brank;
    logic [4:0]      r_oidx;
    logic            r_ohit, r_odv, r_full;
    logic [1:0]      r_ost;
    logic [4:0]      r_res_idx;
    logic            r_res_hit, r_res_dv;
    logic [1:0]      r_res_st;

    logic          w_last, w_match, w_free, w_srange, w_age, w_load;
    logic [SB-1:0] w_s;

    assign w_last   = (r_i == SB'(lbc_pkg::SLOTS - 1));
    assign w_match  = (r_tdev[r_i] == r_it.device) && (r_tblk[r_i] == r_it.block_number);
    assign w_free   = (r_cnt[r_i] == '0);
    assign w_srange = ({3'b0, r_it.slot} < 8'(lbc_pkg::SLOTS));
    assign w_s      = SB'(r_it.slot);
    // release that drops the count to zero needs the aging sweep
    assign w_age    = (r_it.cmd == lbc_pkg::CMD_RELEASE) && w_srange
                      && (r_cnt[w_s] == lbc_pkg::COUNT_BITS'(1));
    // finished result moves to the output register once it is free
    assign w_load   = (r_state == lbc_pkg::S_DONE) && (!r_full || i_pop);
    assign o_take   = (r_state == lbc_pkg::S_IDLE) && i_avail;
    assign o_empty      = !r_full;
    assign o_slot_index = r_res_idx;
    assign o_hit        = r_res_hit;
    assign o_data_valid = r_res_dv;
    assign o_status     = r_res_st;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lbc_pkg::S_IDLE:  if (i_avail) n_state = lbc_pkg::S_HSCAN;
            lbc_pkg::S_HSCAN: n_state = lbc_pkg::S_HSCAN;
            lbc_pkg::S_FSCAN: n_state = lbc_pkg::S_FSCAN;
            lbc_pkg::S_AGE:   n_state = lbc_pkg::S_AGE;
            lbc_pkg::S_DONE:  if (w_load) n_state = lbc_pkg::S_IDLE;
            default:          n_state = lbc_pkg::S_IDLE;
        endcase
        if (r_state == lbc_pkg::S_HSCAN) begin
            if (r_it.cmd != lbc_pkg::CMD_GET) begin
                n_state = w_age ? lbc_pkg::S_AGE : lbc_pkg::S_DONE;
            end else if (w_last) begin
                n_state = (r_found || w_match) ? lbc_pkg::S_DONE : lbc_pkg::S_FSCAN;
            end
        end
        if (r_state == lbc_pkg::S_FSCAN && w_last) n_state = lbc_pkg::S_DONE;
        if (r_state == lbc_pkg::S_AGE && w_last) n_state = lbc_pkg::S_DONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= lbc_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_full <= 1'b0;
        else if (w_load) r_full <= 1'b1;
        else if (i_pop && r_full) r_full <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res_idx <= r_oidx;
            r_res_hit <= r_ohit;
            r_res_dv  <= r_odv;
            r_res_st  <= r_ost;
        end
    end

    // sequencer datapath and slot table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            for (int k = 0; k < lbc_pkg::SLOTS; k++) begin
                r_tdev[k] <= '0;
                r_tblk[k] <= '0;
                r_cnt[k]  <= '0;
                r_rank[k] <= SB'(k);
            end
        end else begin
            case (r_state)
                lbc_pkg::S_IDLE: begin
                    if (i_avail) begin
                        r_it    <= i_item;
                        r_i     <= '0;
                        r_found <= 1'b0;
                    end
                end
                lbc_pkg::S_HSCAN: begin
                    if (r_it.cmd == lbc_pkg::CMD_GET) begin
                        logic bf;
                        logic [SB-1:0] bb;
                        bf = r_found;
                        bb = r_best;
                        if (w_match && (!r_found || r_rank[r_i] > r_brank)) begin
                            bf = 1'b1;
                            bb = r_i;
                            r_brank <= r_rank[r_i];
                        end
                        r_found <= bf;
                        r_best  <= bb;
                        r_i     <= r_i + 1'b1;
                        if (w_last) begin
                            r_found <= 1'b0;
                            r_i     <= '0;
                            if (bf) begin
                                r_oidx <= 5'(bb);
                                r_ohit <= 1'b1;
                                r_odv  <= r_vld[bb];
                                if (r_cnt[bb] == lbc_pkg::COUNT_MAX) r_ost <= lbc_pkg::ST_SAT;
                                else begin
                                    r_ost <= lbc_pkg::ST_OK;
                                    r_cnt[bb] <= r_cnt[bb] + 1'b1;
                                end
                            end
                        end
                    end else if (r_it.cmd == lbc_pkg::CMD_RELEASE) begin
                        r_oidx <= r_it.slot;
                        r_ohit <= 1'b0;
                        if (!w_srange) begin
                            r_odv <= 1'b0;
                            r_ost <= lbc_pkg::ST_UNREF;
                        end else if (r_cnt[w_s] == '0) begin
                            r_odv <= r_vld[w_s];
                            r_ost <= lbc_pkg::ST_UNREF;
                        end else begin
                            r_odv <= r_vld[w_s];
                            r_ost <= lbc_pkg::ST_OK;
                            r_cnt[w_s] <= r_cnt[w_s] - 1'b1;
                            // remember the old rank for the aging sweep
                            if (w_age) begin
                                r_i     <= '0;
                                r_brank <= r_rank[w_s];
                            end
                        end
                    end else if (r_it.cmd == lbc_pkg::CMD_MARK) begin
                        r_oidx <= r_it.slot;
                        r_ohit <= 1'b0;
                        r_ost  <= lbc_pkg::ST_OK;
                        r_odv  <= w_srange;
                        if (w_srange) r_vld[w_s] <= 1'b1;
                    end else begin
                        r_oidx <= '0;
                        r_ohit <= 1'b0;
                        r_odv  <= 1'b0;
                        r_ost  <= lbc_pkg::ST_OK;
                    end
                end
                lbc_pkg::S_FSCAN: begin
                    logic bf;
                    logic [SB-1:0] bb;
                    bf = r_found;
                    bb = r_best;
                    if (w_free && (!r_found || r_rank[r_i] < r_brank)) begin
                        bf = 1'b1;
                        bb = r_i;
                        r_brank <= r_rank[r_i];
                    end
                    r_found <= bf;
                    r_best  <= bb;
                    r_i     <= r_i + 1'b1;
                    if (w_last) begin
                        r_ohit <= 1'b0;
                        r_odv  <= 1'b0;
                        if (bf) begin
                            r_oidx <= 5'(bb);
                            r_ost  <= lbc_pkg::ST_OK;
                            r_tdev[bb] <= r_it.device;
                            r_tblk[bb] <= r_it.block_number;
                            r_vld[bb]  <= 1'b0;
                            r_cnt[bb]  <= lbc_pkg::COUNT_BITS'(1);
                        end else begin
                            r_oidx <= '0;
                            r_ost  <= lbc_pkg::ST_NOBUF;
                        end
                    end
                end
                lbc_pkg::S_AGE: begin
                    // move released slot to most recent, one slot a cycle
                    if (r_i == w_s) r_rank[r_i] <= SB'(lbc_pkg::SLOTS - 1);
                    else if (r_rank[r_i] > r_brank) r_rank[r_i] <= r_rank[r_i] - 1'b1;
                    r_i <= r_i + 1'b1;
                end
                default: ;
            endcase
        end
    end

`ifndef ASSERT_OFF
    // a waiting beat holds still until popped
    a_hold_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_full && !i_pop) |=>
        (r_full && $stable({r_res_idx, r_res_hit, r_res_dv, r_res_st})));
    // new work is taken only from idle
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != lbc_pkg::S_IDLE) |-> !o_take);
    // no free buffer reports all other fields as zero
    a_nobuf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_full && r_res_st == lbc_pkg::ST_NOBUF) |->
        (r_res_idx == '0 && !r_res_hit && !r_res_dv));
    // a hit is either ok or saturated
    a_hit_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_full && r_res_hit) |->
        (r_res_st != lbc_pkg::ST_NOBUF && r_res_st != lbc_pkg::ST_UNREF));
`endif
endmodule

// ===== rtl/lru_block_buffer_cache.sv =====
// LRU block buffer cache top level: front queue plus back sequencer.
// Get: tag scan, then free-slot scan on a miss; release to zero adds aging sweep.
// One item at a time in the back; the front queues two more items.
// Throughput is set by the slot scan, one slot compared per cycle, and by result pops.
// Synchronous active-low reset clears tags, counts, marks; ranks to slot index.
// Depends on lbc_pkg, lbc_front, lbc_back.
module lru_block_buffer_cache (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_device,
    input  logic [31:0] i_block_number,
    input  logic [4:0]  i_slot,
    output logic        empty,
    input  logic        pop,
    output logic [4:0]  o_slot_index,
    output logic        o_hit,
    output logic        o_data_valid,
    output logic [1:0]  o_status
);
    lbc_pkg::t_item w_in, w_q;
    logic w_avail, w_take;

    assign w_in = '{cmd: i_cmd, device: i_device, block_number: i_block_number,
                    slot: i_slot};

    lbc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_item(w_in), .o_avail(w_avail), .o_item(w_q), .i_take(w_take)
    );

    lbc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_avail(w_avail), .i_item(w_q),
        .o_take(w_take), .o_empty(empty), .i_pop(pop),
        .o_slot_index(o_slot_index), .o_hit(o_hit),
        .o_data_valid(o_data_valid), .o_status(o_status)
    );
endmodule

// ===== dv/lru_block_buffer_cache_test.sv =====
// Self-checking testbench for the LRU block buffer cache: directed table, then random traffic.
// Results are checked against a cycle-free behavioral predictor of the cache state.
// Depends on lbc_pkg and lru_block_buffer_cache.
module lru_block_buffer_cache_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 900000;

    typedef struct packed {
        logic [4:0] slot_index;
        logic       hit;
        logic       data_valid;
        logic [1:0] status;
    } t_res;

    // directed row: item plus optional typed-in expectation
    typedef struct {
        lbc_pkg::t_item item;
        bit             fixed;
        t_res           res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [1:0]  i_cmd;
    logic [7:0]  i_device;
    logic [31:0] i_block_number;
    logic [4:0]  i_slot;
    logic        empty;
    logic        pop;
    logic [4:0]  o_slot_index;
    logic        o_hit;
    logic        o_data_valid;
    logic [1:0]  o_status;

    lru_block_buffer_cache i_dut (.*);

    // predictor copy of the cache state
    logic [lbc_pkg::DEV_BITS-1:0]   cache_dev  [lbc_pkg::SLOTS];
    logic [lbc_pkg::BLK_BITS-1:0]   cache_blk  [lbc_pkg::SLOTS];
    logic                           cache_vld  [lbc_pkg::SLOTS];
    logic [lbc_pkg::COUNT_BITS-1:0] cache_refs [lbc_pkg::SLOTS];
    int unsigned                    cache_rank [lbc_pkg::SLOTS];

    t_res        pending_results[$];
    int          fail_count;
    int unsigned cycle_count;
    int          send_idle_pct;
    int          recv_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** lru_block_buffer_cache: FAILED **");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
                 cycle_count);
        fail_count++;
    endtask

    function automatic void cache_clear();
        for (int i = 0; i < lbc_pkg::SLOTS; i++) begin
            cache_dev[i] = '0;
            cache_blk[i] = '0;
            cache_vld[i] = 1'b0;
            cache_refs[i] = '0;
            cache_rank[i] = i;
        end
    endfunction

    // apply one command to the predictor and return its result
    function automatic t_res cache_apply(input lbc_pkg::t_item it);
        t_res r;
        bit found;
        int best;
        int unsigned best_rank;
        int unsigned old_rank;
        r = '0;
        found = 0;
        best = 0;
        best_rank = 0;
        case (it.cmd)
            lbc_pkg::CMD_GET: begin
                for (int i = 0; i < lbc_pkg::SLOTS; i++)
                    if (cache_dev[i] == it.device && cache_blk[i] == it.block_number &&
                        (!found || cache_rank[i] > best_rank)) begin
                        found = 1;
                        best = i;
                        best_rank = cache_rank[i];
                    end
                if (found) begin
                    if (cache_refs[best] == lbc_pkg::COUNT_MAX) r.status = lbc_pkg::ST_SAT;
                    else cache_refs[best]++;
                    r.slot_index = 5'(best);
                    r.hit = 1'b1;
                    r.data_valid = cache_vld[best];
                end else begin
                    for (int i = 0; i < lbc_pkg::SLOTS; i++)
                        if (cache_refs[i] == 0 && (!found || cache_rank[i] < best_rank)) begin
                            found = 1;
                            best = i;
                            best_rank = cache_rank[i];
                        end
                    if (!found) begin
                        r.status = lbc_pkg::ST_NOBUF;
                    end else begin
                        cache_dev[best] = it.device;
                        cache_blk[best] = it.block_number;
                        cache_vld[best] = 1'b0;
                        cache_refs[best] = lbc_pkg::COUNT_BITS'(1);
                        r.slot_index = 5'(best);
                    end
                end
            end
            lbc_pkg::CMD_RELEASE: begin
                r.slot_index = it.slot;
                if (it.slot >= lbc_pkg::SLOTS) begin
                    r.status = lbc_pkg::ST_UNREF;
                end else if (cache_refs[it.slot] == 0) begin
                    r.status = lbc_pkg::ST_UNREF;
                    r.data_valid = cache_vld[it.slot];
                end else begin
                    cache_refs[it.slot]--;
                    if (cache_refs[it.slot] == 0) begin
                        old_rank = cache_rank[it.slot];
                        for (int i = 0; i < lbc_pkg::SLOTS; i++)
                            if (cache_rank[i] > old_rank) cache_rank[i]--;
                        cache_rank[it.slot] = lbc_pkg::SLOTS - 1;
                    end
                    r.data_valid = cache_vld[it.slot];
                end
            end
            lbc_pkg::CMD_MARK: begin
                r.slot_index = it.slot;
                if (it.slot < lbc_pkg::SLOTS) begin
                    cache_vld[it.slot] = 1'b1;
                    r.data_valid = 1'b1;
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    // drive one beat and wait for acceptance; push stays high between back-to-back beats
    task automatic send_beat(input lbc_pkg::t_item it, input bit fixed, input t_res want);
        t_res r;
        r = cache_apply(it);
        if (fixed && r !== want) report_mismatch("directed prediction", int'(r), int'(want));
        pending_results.push_back(fixed ? want : r);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_cmd <= it.cmd;
        i_device <= it.device;
        i_block_number <= it.block_number;
        i_slot <= it.slot;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    // result side: random stalls and field checks
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected beat slot_index", o_slot_index, -1);
                end else begin
                    want = pending_results.pop_front();
                    if (o_slot_index !== want.slot_index)
                        report_mismatch("slot_index", o_slot_index, want.slot_index);
                    if (o_hit !== want.hit) report_mismatch("hit", o_hit, want.hit);
                    if (o_data_valid !== want.data_valid)
                        report_mismatch("data_valid", o_data_valid, want.data_valid);
                    if (o_status !== want.status)
                        report_mismatch("status", o_status, want.status);
                end
            end
            pop <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic lbc_pkg::t_item make_item(input logic [1:0] c, input logic [7:0] d,
                                                 input logic [31:0] b, input logic [4:0] s);
        lbc_pkg::t_item it;
        it.cmd = c;
        it.device = d;
        it.block_number = b;
        it.slot = s;
        return it;
    endfunction

    function automatic t_res make_res(input logic [4:0] s, input bit h, input bit v,
                                      input logic [1:0] st);
        t_res r;
        r.slot_index = s;
        r.hit = h;
        r.data_valid = v;
        r.status = st;
        return r;
    endfunction

    // random item: half gets, mostly over a small working set, with releases mostly of held slots
    function automatic lbc_pkg::t_item random_item();
        int pick;
        int s;
        pick = $urandom_range(99);
        if (pick < 50) begin
            if ($urandom_range(3) == 0)
                return make_item(lbc_pkg::CMD_GET, 8'($urandom), $urandom, 5'($urandom));
            return make_item(lbc_pkg::CMD_GET, 8'($urandom_range(3)),
                             32'($urandom_range(40)), 5'($urandom));
        end
        if (pick < 85) begin
            s = $urandom_range(lbc_pkg::SLOTS - 1);
            for (int i = 0; i < 8 && cache_refs[s] == 0; i++)
                s = $urandom_range(lbc_pkg::SLOTS - 1);
            return make_item(lbc_pkg::CMD_RELEASE, 8'($urandom), $urandom, 5'(s));
        end
        if (pick < 97)
            return make_item(lbc_pkg::CMD_MARK, 8'($urandom), $urandom, 5'($urandom));
        return make_item(CMD_UNUSED, 8'($urandom), $urandom, 5'($urandom));
    endfunction

    initial begin
        t_row table_rows[$];
        lbc_pkg::t_item it;
        int phase_len;
        push = 1'b0;
        pop = 1'b0;
        i_cmd = '0;
        i_device = '0;
        i_block_number = '0;
        i_slot = '0;
        i_rst_n = 1'b0;
        fail_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cache_clear();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table; typed-in results where obvious
        table_rows.push_back('{make_item(lbc_pkg::CMD_GET, 8'd0, 32'd0, 5'd0), 1,
                               make_res(5'd31, 1, 0, lbc_pkg::ST_OK)});
        table_rows.push_back('{make_item(lbc_pkg::CMD_RELEASE, 8'd0, 32'd0, 5'd3), 1,
                               make_res(5'd3, 0, 0, lbc_pkg::ST_UNREF)});
        table_rows.push_back('{make_item(lbc_pkg::CMD_MARK, 8'hff, 32'hffff_ffff, 5'd31), 1,
                               make_res(5'd31, 0, 1, lbc_pkg::ST_OK)});
        table_rows.push_back('{make_item(CMD_UNUSED, 8'hff, 32'hffff_ffff, 5'd31), 1,
                               make_res(5'd0, 0, 0, lbc_pkg::ST_OK)});
        table_rows.push_back('{make_item(lbc_pkg::CMD_GET, 8'hff, 32'hffff_ffff, 5'd0), 1,
                               make_res(5'd0, 0, 0, lbc_pkg::ST_OK)});
        table_rows.push_back('{make_item(lbc_pkg::CMD_GET, 8'hff, 32'hffff_ffff, 5'd0), 1,
                               make_res(5'd0, 1, 0, lbc_pkg::ST_OK)});
        table_rows.push_back('{make_item(lbc_pkg::CMD_MARK, 8'd0, 32'd0, 5'd0), 0, '0});
        table_rows.push_back('{make_item(lbc_pkg::CMD_RELEASE, 8'd0, 32'd0, 5'd0), 0, '0});
        table_rows.push_back('{make_item(lbc_pkg::CMD_RELEASE, 8'd0, 32'd0, 5'd0), 0, '0});
        table_rows.push_back('{make_item(lbc_pkg::CMD_RELEASE, 8'd0, 32'd0, 5'd31), 0, '0});
        table_rows.push_back('{make_item(lbc_pkg::CMD_GET, 8'h5a, 32'h8000_0001, 5'd0), 0, '0});
        table_rows.push_back('{make_item(lbc_pkg::CMD_GET, 8'h01, 32'h0000_0001, 5'd0), 0, '0});
        foreach (table_rows[i]) send_beat(table_rows[i].item, table_rows[i].fixed,
                                          table_rows[i].res);

        // fill every slot, then one more get has nowhere to go
        for (int i = 0; i < lbc_pkg::SLOTS; i++)
            send_beat(make_item(lbc_pkg::CMD_GET, 8'h77, i, 5'd0), 0, '0);
        send_beat(make_item(lbc_pkg::CMD_GET, 8'h88, 32'd1, 5'd0), 1,
                  make_res(5'd0, 0, 0, lbc_pkg::ST_NOBUF));
        // saturate one slot's reference count
        for (int i = 0; i < lbc_pkg::COUNT_MAX + 1; i++)
            send_beat(make_item(lbc_pkg::CMD_GET, 8'h77, 32'd5, 5'd0), 0, '0);
        // drop the other references; the saturated slot stays held
        for (int i = 0; i < lbc_pkg::SLOTS; i++)
            while (cache_refs[i] != 0 && cache_refs[i] != lbc_pkg::COUNT_MAX)
                send_beat(make_item(lbc_pkg::CMD_RELEASE, 8'd0, 32'd0, 5'(i)), 0, '0);

        // random phases with different idle/stall pressure
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            phase_len = 80;
            for (int n = 0; n < phase_len; n++) begin
                it = random_item();
                send_beat(it, 0, '0);
            end
        end
        push <= 1'b0;

        // drain, then allow for the back end to settle
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2 * lbc_pkg::SLOTS + 20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** lru_block_buffer_cache: PASSED **");
        end else begin
            $display("** lru_block_buffer_cache: FAILED **");
        end
        $finish;
    end
endmodule
